@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define QMD_ASSERT_CLK(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define QMD_ASSERT(name, prop, msg) `QMD_ASSERT_CLK(name, aclk, aresetn, prop, msg)
`else
`define QMD_ASSERT_CLK(name, clk, rstn, prop, msg)
`define QMD_ASSERT(name, prop, msg)
`endif
`endif

@@ design/qmd_pkg.sv @@
// ----------------------------------------------------------------------------
// qmd_pkg
// shared types and constants of the qam mapper / demapper
// ----------------------------------------------------------------------------
package qmd_pkg;

    localparam int MAX_POINTS    = 256;
    localparam int ADDR_W        = $clog2(MAX_POINTS);
    localparam int COORD_W       = 5;
    localparam int ENTRY_W       = 2 * COORD_W;
    localparam int OP_W          = 2;
    localparam int LABEL_W       = 8;
    localparam int POS_W         = 8;
    localparam int IN_W          = 20;
    localparam int OUT_W         = 21;
    localparam int H_W           = 16;
    localparam int HS_W          = H_W + 1;
    localparam int MUL_W         = COORD_W + HS_W;
    localparam int DIFF_W        = OUT_W + 1;
    localparam int SQ_FULL_W     = 2 * DIFF_W;
    localparam int SQ_W          = SQ_FULL_W - 1;
    localparam int DIST_W        = SQ_W + 1;
    localparam int MODE_W        = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = H_W;
    localparam int DRAIN_CYCLES  = 4;
    localparam int DRAIN_W       = $clog2(DRAIN_CYCLES);
    localparam int SIDE_W        = 4;

    localparam logic [MODE_W-1:0]  MODE_BIG         = 4'd8;
    localparam logic [MODE_W-1:0]  MODE_RST         = 4'd4;
    localparam logic [H_W-1:0]     HALF_DIST_RST    = 16'd4096;
    localparam logic [LABEL_W-1:0] LABEL_MASK_BIG   = 8'hff;
    localparam logic [LABEL_W-1:0] LABEL_MASK_SMALL = 8'h0f;
    localparam logic [ADDR_W-1:0]  LAST_BIG         = 8'd255;
    localparam logic [ADDR_W-1:0]  LAST_SMALL       = 8'd15;
    localparam logic [COORD_W-1:0] TOP_BIG          = 5'd15;
    localparam logic [COORD_W-1:0] TOP_SMALL        = 5'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_DIST = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_DECODE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ENC_MUL,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic latch;
        logic load_wr;
        logic rd_en;
        logic rd_scan;
        logic scan_clr;
        logic scan_inc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scan_last;
    } sts_t;

endpackage

@@ design/qam_mapper_demapper.sv @@
// ----------------------------------------------------------------------------
// qam_mapper_demapper
// square 16/256-qam mapper and hard demapper with a loadable labelling
// ----------------------------------------------------------------------------
// input words arrive on s_* with valid/ready, results leave on m_* with
// valid/ready; the user must write registers through cfg_wr_en/cfg_index/
// cfg_wdata only while the block is idle, the block does not enforce it.
// index 0 sets the mode (8 gives 256-qam), index 1 the half point spacing.
// one word is in work at a time; s_ready is high only when idle.
// load gives no result. encode reads the labelled entry and registers the
// scaled point before the result is loaded. decode scans n = 16 or 256
// points; the point table ram gives one entry per cycle into a four stage
// scale/difference/square/compare pipeline; that single read port sets the
// decode time. a next word can be taken in the cycle after a result load.
// results sit in an output register, so a stalled receiver does not stop
// the next word from being accepted and worked on; only the following
// result waits until the register is taken.
// reset returns the mode to 16-qam and the spacing to 1.0; the point table
// keeps no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qam_mapper_demapper (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [qmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qmd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [qmd_pkg::OP_W-1:0]           s_operation,
    input  logic [qmd_pkg::LABEL_W-1:0]        s_label,
    input  logic [qmd_pkg::POS_W-1:0]          s_grid_position,
    input  logic signed [qmd_pkg::IN_W-1:0]    s_in_x,
    input  logic signed [qmd_pkg::IN_W-1:0]    s_in_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_result_kind,
    output logic [qmd_pkg::LABEL_W-1:0]        m_out_label,
    output logic signed [qmd_pkg::OUT_W-1:0]   m_out_x,
    output logic signed [qmd_pkg::OUT_W-1:0]   m_out_y
);
    import qmd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    qmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    qmd_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_operation     (s_operation),
        .s_label         (s_label),
        .s_grid_position (s_grid_position),
        .s_in_x          (s_in_x),
        .s_in_y          (s_in_y),
        .cmd             (cmd),
        .sts             (sts),
        .m_result_kind   (m_result_kind),
        .m_out_label     (m_out_label),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y)
    );

    `QMD_ASSERT(a_no_overwrite, cmd.out_load |-> (!m_valid || m_ready), "output word overwritten")
    `QMD_ASSERT(a_one_in_work, (s_valid && s_ready) |=> !s_ready, "second word taken while busy")
    `QMD_ASSERT(a_decode_zero_xy, (m_valid && m_result_kind) |-> (m_out_x == '0 && m_out_y == '0), "decode word carries coordinates")

endmodule

@@ design/qmd_ram.sv @@
// ----------------------------------------------------------------------------
// qmd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module qmd_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/qmd_ctrl.sv @@
// ----------------------------------------------------------------------------
// qmd_ctrl
// sequencer for load, encode and decode words and the output register valid
// ----------------------------------------------------------------------------
module qmd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          m_ready,
    output logic          m_valid,
    input  qmd_pkg::sts_t sts,
    output qmd_pkg::cmd_t cmd
);
    import qmd_pkg::*;

    state_t             state_reg, state_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            drain_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            drain_reg   <= drain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        drain_next = drain_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                drain_next = '0;
                case (sts.op)
                    OP_ENCODE: state_next = ST_ENC_MUL;
                    OP_DECODE: state_next = ST_SCAN;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_ENC_MUL: begin
                state_next = ST_FINISH;
            end
            ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
            end
            ST_DISPATCH: begin
                cmd.load_wr  = (sts.op == OP_LOAD);
                cmd.rd_en    = (sts.op == OP_ENCODE);
                cmd.scan_clr = 1'b1;
            end
            ST_SCAN: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_scan  = 1'b1;
                cmd.scan_inc = 1'b1;
            end
            ST_FINISH: begin
                cmd.out_load = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ design/qmd_datapath.sv @@
// ----------------------------------------------------------------------------
// qmd_datapath
// config registers, point table, distance pipeline, best tracker, output word
// ----------------------------------------------------------------------------
module qmd_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [qmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qmd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [qmd_pkg::OP_W-1:0]           s_operation,
    input  logic [qmd_pkg::LABEL_W-1:0]        s_label,
    input  logic [qmd_pkg::POS_W-1:0]          s_grid_position,
    input  logic signed [qmd_pkg::IN_W-1:0]    s_in_x,
    input  logic signed [qmd_pkg::IN_W-1:0]    s_in_y,
    input  qmd_pkg::cmd_t                      cmd,
    output qmd_pkg::sts_t                      sts,
    output logic                               m_result_kind,
    output logic [qmd_pkg::LABEL_W-1:0]        m_out_label,
    output logic signed [qmd_pkg::OUT_W-1:0]   m_out_x,
    output logic signed [qmd_pkg::OUT_W-1:0]   m_out_y
);
    import qmd_pkg::*;

    logic [MODE_W-1:0]         mode_reg, mode_next;
    logic [H_W-1:0]            half_reg, half_next;
    logic                      big;

    logic [OP_W-1:0]           op_reg;
    logic [LABEL_W-1:0]        label_reg;
    logic [POS_W-1:0]          pos_reg;
    logic signed [IN_W-1:0]    cx_reg, cy_reg;

    logic [ADDR_W-1:0]         cnt_reg, cnt_next;

    logic [SIDE_W-1:0]         col, row;
    logic [COORD_W-1:0]        top, ent_x, ent_y;
    logic                      pos_ok;

    logic                      ram_we, ram_re;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]        ram_rdata;

    logic signed [COORD_W-1:0] px, py;
    logic signed [HS_W-1:0]    hs;
    logic signed [MUL_W-1:0]   mul_x, mul_y;
    logic signed [OUT_W-1:0]   prod_x_reg, prod_y_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg, dx_next, dy_next;
    logic signed [SQ_FULL_W-1:0] sqx_full, sqy_full;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg;
    logic [DIST_W-1:0]         dist_sum;

    logic                      v1_reg, v2_reg, v3_reg, v4_reg;
    logic [ADDR_W-1:0]         idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [DIST_W-1:0]         best_d_reg;
    logic [ADDR_W-1:0]         best_idx_reg;
    logic                      take;

    // config registers
    always_comb begin
        mode_next = mode_reg;
        half_next = half_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MODE:      mode_next = cfg_wdata[MODE_W-1:0];
                CFG_HALF_DIST: half_next = cfg_wdata;
                default:       mode_next = mode_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RST;
            half_reg <= HALF_DIST_RST;
        end else begin
            mode_reg <= mode_next;
            half_reg <= half_next;
        end
    end

    assign big = (mode_reg == MODE_BIG);

    // input word capture
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg    <= s_operation;
            label_reg <= s_label & (big ? LABEL_MASK_BIG : LABEL_MASK_SMALL);
            pos_reg   <= s_grid_position;
            cx_reg    <= s_in_x;
            cy_reg    <= s_in_y;
        end
    end

    // scan counter
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.scan_clr) begin
            cnt_next = '0;
        end else if (cmd.scan_inc) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign sts = '{op: op_reg, scan_last: (cnt_reg == (big ? LAST_BIG : LAST_SMALL))};

    // grid position to point
    always_comb begin
        if (big) begin
            col    = pos_reg[SIDE_W-1:0];
            row    = pos_reg[2*SIDE_W-1:SIDE_W];
            top    = TOP_BIG;
            pos_ok = 1'b1;
        end else begin
            col    = {2'b00, pos_reg[1:0]};
            row    = {2'b00, pos_reg[3:2]};
            top    = TOP_SMALL;
            pos_ok = (pos_reg[POS_W-1:SIDE_W] == '0);
        end
        ent_x = {col, 1'b0} - top;
        ent_y = top - {row, 1'b0};
    end

    assign ram_we    = cmd.load_wr && pos_ok;
    assign ram_re    = cmd.rd_en;
    assign ram_raddr = cmd.rd_scan ? cnt_reg : label_reg;

    qmd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (label_reg),
        .wr_data ({ent_y, ent_x}),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // scaling stage
    assign px    = ram_rdata[COORD_W-1:0];
    assign py    = ram_rdata[ENTRY_W-1:COORD_W];
    assign hs    = {1'b0, half_reg};
    assign mul_x = px * hs;
    assign mul_y = py * hs;

    // difference and square stages
    assign dx_next  = {{(DIFF_W-IN_W){cx_reg[IN_W-1]}}, cx_reg}
                    - {prod_x_reg[OUT_W-1], prod_x_reg};
    assign dy_next  = {{(DIFF_W-IN_W){cy_reg[IN_W-1]}}, cy_reg}
                    - {prod_y_reg[OUT_W-1], prod_y_reg};
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;
    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge aclk) begin
        prod_x_reg <= mul_x[OUT_W-1:0];
        prod_y_reg <= mul_y[OUT_W-1:0];
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sqx_reg    <= sqx_full[SQ_W-1:0];
        sqy_reg    <= sqy_full[SQ_W-1:0];
        idx1_reg   <= cnt_reg;
        idx2_reg   <= idx1_reg;
        idx3_reg   <= idx2_reg;
        idx4_reg   <= idx3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en && cmd.rd_scan;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // nearest point, lowest label wins ties
    assign take = v4_reg && ((idx4_reg == '0) || (dist_sum < best_d_reg));

    always_ff @(posedge aclk) begin
        if (take) begin
            best_d_reg   <= dist_sum;
            best_idx_reg <= idx4_reg;
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (op_reg)
                OP_DECODE: begin
                    m_result_kind <= 1'b1;
                    m_out_label   <= best_idx_reg;
                    m_out_x       <= '0;
                    m_out_y       <= '0;
                end
                default: begin
                    m_result_kind <= 1'b0;
                    m_out_label   <= '0;
                    m_out_x       <= prod_x_reg;
                    m_out_y       <= prod_y_reg;
                end
            endcase
        end
    end

endmodule
